[hdl/sorted_descending_priority_list_unit_assert.svh]
// Assertion macros for the sorted descending priority list unit.
// Used by the checker module; no other dependencies.
`ifndef SORTED_DESCENDING_PRIORITY_LIST_UNIT_ASSERT_SVH
`define SORTED_DESCENDING_PRIORITY_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SDPL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define SDPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sdpl_pkg.sv]
// Package for the sorted descending priority list unit.
// Holds operation and status codes, the sequencer states and cell commands.
package sdpl_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAIL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_HEAD,
    ST_INS_EXTRA,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_POP_TAIL
  } cell_op_t;

endpackage

[hdl/sdpl_in_if.sv]
// Input channel of the sorted descending priority list unit.
// Depends on sdpl_pkg for the operation code width.
interface sdpl_in_if #(
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic [sdpl_pkg::FUNC_W-1:0] func;
  logic [KEY_WIDTH-1:0]        item_key;
  logic [TAG_WIDTH-1:0]        item_tag;
  logic [KEY_WIDTH-1:0]        extra_key;
  logic [TAG_WIDTH-1:0]        extra_tag;

  modport source (output valid, func, item_key, item_tag, extra_key, extra_tag,
                  input ready);
  modport sink   (input valid, func, item_key, item_tag, extra_key, extra_tag,
                  output ready);
endinterface

// Result channel of the sorted descending priority list unit.
interface sdpl_out_if #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [TAG_WIDTH-1:0]          head_tag;
  logic [KEY_WIDTH-1:0]          head_key;
  logic [CNT_W-1:0]              entry_total;
  logic [sdpl_pkg::STATUS_W-1:0] status;

  modport source (output valid, head_tag, head_key, entry_total, status,
                  input ready);
  modport sink   (input valid, head_tag, head_key, entry_total, status,
                  output ready);
endinterface

[hdl/sdpl_cell.sv]
// One slot of the sorted list: holds a (tag, key) entry and trades it with
// its neighbours. Depends on sdpl_pkg for the cell command type.
module sdpl_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16,
  parameter int CNT_W     = 9,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  sdpl_pkg::cell_op_t   op,
  input  logic [CNT_W-1:0]     count,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [TAG_WIDTH-1:0] new_tag,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [TAG_WIDTH-1:0] left_tag,
  input  logic [KEY_WIDTH-1:0] right_key,
  input  logic [TAG_WIDTH-1:0] right_tag,
  input  logic                 found_in,
  output logic                 found_out,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic [TAG_WIDTH-1:0] tag_o
);

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] TAIL_CNT = CNT_W'(IDX + 1);

  logic [KEY_WIDTH-1:0] key_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic                 occupied;
  logic                 not_above;

  assign occupied  = POS < count;
  // An empty slot, or a key not above the new one, marks the insert point.
  assign not_above = !occupied || (key_r <= new_key);
  assign found_out = found_in | not_above;
  assign key_o     = key_r;
  assign tag_o     = tag_r;

  always_ff @(posedge clk) begin
    case (op)
      sdpl_pkg::CELL_INSERT: begin
        if (found_in) begin
          key_r <= left_key;
          tag_r <= left_tag;
        end else if (not_above) begin
          key_r <= new_key;
          tag_r <= new_tag;
        end
      end
      sdpl_pkg::CELL_POP: begin
        key_r <= right_key;
        tag_r <= right_tag;
      end
      sdpl_pkg::CELL_POP_TAIL: begin
        if (count == TAIL_CNT) begin
          key_r <= new_key;
          tag_r <= new_tag;
        end else begin
          key_r <= right_key;
          tag_r <= right_tag;
        end
      end
      default: begin
        key_r <= key_r;
        tag_r <= tag_r;
      end
    endcase
  end

endmodule

[hdl/sorted_descending_priority_list_unit.sv]
// Sorted descending priority list: load, head-to-tail and clear go from accept
// straight to the report state; pop-and-reinsert first passes the insert-head and
// insert-extra states, as it needs one shift pass and two insert passes over the cell row.
// A new item is taken only in the idle state, after the last item's report; a held
// result stalls the next item only in its report state. Reset (rst_n,
// synchronous) clears count, status, sequencer and result valid; cells stay undefined.
module sorted_descending_priority_list_unit #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sdpl_in_if.sink    in_if,
  sdpl_out_if.source out_if
);

  localparam int               CNT_W   = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // Sequencer and count
  sdpl_pkg::state_t            state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [sdpl_pkg::STATUS_W-1:0] status_r, status_nxt;

  // Operands held across the pop-and-reinsert passes
  logic [KEY_WIDTH-1:0] ikey_r;
  logic [TAG_WIDTH-1:0] htag_r;
  logic [KEY_WIDTH-1:0] xkey_r;
  logic [TAG_WIDTH-1:0] xtag_r;

  // Result register
  logic                          out_valid_r;
  logic [TAG_WIDTH-1:0]          out_tag_r;
  logic [KEY_WIDTH-1:0]          out_key_r;
  logic [CNT_W-1:0]              out_total_r;
  logic [sdpl_pkg::STATUS_W-1:0] out_status_r;

  // Broadcast to the cell row
  sdpl_pkg::cell_op_t   cell_op;
  logic [KEY_WIDTH-1:0] bcast_key;
  logic [TAG_WIDTH-1:0] bcast_tag;

  // Cell row
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag [DEPTH];
  logic                 found    [DEPTH];

  logic accept;
  logic out_free;
  logic is_empty;
  logic is_full;
  logic pop_go;

  // Take no item while reset is held.
  assign in_if.ready = rst_n && (state_r == sdpl_pkg::ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == DEPTH_C);
  // Pop-and-reinsert goes ahead only with the list neither empty nor full.
  assign pop_go      = (in_if.func == sdpl_pkg::FUNC_POP) && !is_empty && !is_full;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdpl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pop_go ? sdpl_pkg::ST_INS_HEAD : sdpl_pkg::ST_REPORT;
        end
      end
      sdpl_pkg::ST_INS_HEAD:  state_nxt = sdpl_pkg::ST_INS_EXTRA;
      sdpl_pkg::ST_INS_EXTRA: state_nxt = sdpl_pkg::ST_REPORT;
      sdpl_pkg::ST_REPORT: begin
        if (out_free) begin
          state_nxt = sdpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdpl_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Commands to the cell row, count and status
  // ---------------------------------------------------------------------
  always_comb begin
    cell_op    = sdpl_pkg::CELL_HOLD;
    bcast_key  = in_if.item_key;
    bcast_tag  = in_if.item_tag;
    count_nxt  = count_r;
    status_nxt = status_r;
    unique case (state_r)
      sdpl_pkg::ST_IDLE: begin
        if (accept) begin
          status_nxt = sdpl_pkg::STATUS_OK;
          unique case (in_if.func)
            sdpl_pkg::FUNC_LOAD: begin
              if (is_full) begin
                status_nxt = sdpl_pkg::STATUS_FULL;
              end else begin
                cell_op   = sdpl_pkg::CELL_INSERT;
                count_nxt = count_r + ONE_C;
              end
            end
            sdpl_pkg::FUNC_TAIL: begin
              // Drop the head and park it, with its new key, in the last occupied slot.
              if (is_empty) begin
                status_nxt = sdpl_pkg::STATUS_EMPTY;
              end else begin
                cell_op   = sdpl_pkg::CELL_POP_TAIL;
                bcast_tag = cell_tag[0];
              end
            end
            sdpl_pkg::FUNC_POP: begin
              // Empty takes precedence over full.
              if (is_empty) begin
                status_nxt = sdpl_pkg::STATUS_EMPTY;
              end else if (is_full) begin
                status_nxt = sdpl_pkg::STATUS_FULL;
              end else begin
                cell_op   = sdpl_pkg::CELL_POP;
                count_nxt = count_r - ONE_C;
              end
            end
            sdpl_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      sdpl_pkg::ST_INS_HEAD: begin
        cell_op   = sdpl_pkg::CELL_INSERT;
        bcast_key = ikey_r;
        bcast_tag = htag_r;
        count_nxt = count_r + ONE_C;
      end
      sdpl_pkg::ST_INS_EXTRA: begin
        cell_op   = sdpl_pkg::CELL_INSERT;
        bcast_key = xkey_r;
        bcast_tag = xtag_r;
        count_nxt = count_r + ONE_C;
      end
      sdpl_pkg::ST_REPORT: begin
        cell_op = sdpl_pkg::CELL_HOLD;
      end
      default: begin
        cell_op = sdpl_pkg::CELL_HOLD;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sdpl_pkg::ST_IDLE;
      count_r  <= '0;
      status_r <= sdpl_pkg::STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // Hold the reinsert operands; the head tag is captured before the shift.
  always_ff @(posedge clk) begin
    if (accept) begin
      ikey_r <= in_if.item_key;
      htag_r <= cell_tag[0];
      xkey_r <= in_if.extra_key;
      xtag_r <= in_if.extra_tag;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: load the head once the last pass has settled
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sdpl_pkg::ST_REPORT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sdpl_pkg::ST_REPORT && out_free) begin
      out_tag_r    <= is_empty ? '0 : cell_tag[0];
      out_key_r    <= is_empty ? '0 : cell_key[0];
      out_total_r  <= count_r;
      out_status_r <= status_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.head_tag    = out_tag_r;
  assign out_if.head_key    = out_key_r;
  assign out_if.entry_total = out_total_r;
  assign out_if.status      = out_status_r;

  // ---------------------------------------------------------------------
  // Cell row: cell 0 is the head. The found chain marks the first slot whose
  // key is not above the new one; from there on every slot shifts right.
  // ---------------------------------------------------------------------
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] lkey, rkey;
    logic [TAG_WIDTH-1:0] ltag, rtag;

    if (i == 0) begin : g_first
      assign lkey = bcast_key;
      assign ltag = bcast_tag;
    end else begin : g_mid_l
      assign lkey = cell_key[i-1];
      assign ltag = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = cell_key[i];
      assign rtag = cell_tag[i];
      sdpl_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .CNT_W     (CNT_W),
        .IDX       (i)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op),
        .count     (count_r),
        .new_key   (bcast_key),
        .new_tag   (bcast_tag),
        .left_key  (lkey),
        .left_tag  (ltag),
        .right_key (rkey),
        .right_tag (rtag),
        .found_in  (found[i]),
        .found_out (),
        .key_o     (cell_key[i]),
        .tag_o     (cell_tag[i])
      );
    end else begin : g_mid_r
      assign rkey = cell_key[i+1];
      assign rtag = cell_tag[i+1];
      sdpl_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .CNT_W     (CNT_W),
        .IDX       (i)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op),
        .count     (count_r),
        .new_key   (bcast_key),
        .new_tag   (bcast_tag),
        .left_key  (lkey),
        .left_tag  (ltag),
        .right_key (rkey),
        .right_tag (rtag),
        .found_in  (found[i]),
        .found_out (found[i+1]),
        .key_o     (cell_key[i]),
        .tag_o     (cell_tag[i])
      );
    end
  end

endmodule

[hdl/sdpl_checker.sv]
// Port-level checks on the result channel of the sorted list unit, and the
// bind that attaches them. Depends on sdpl_pkg and the assertion macro header.
`include "sorted_descending_priority_list_unit_assert.svh"

module sdpl_checker #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [TAG_WIDTH-1:0]          out_head_tag,
  input logic [KEY_WIDTH-1:0]          out_head_key,
  input logic [$clog2(DEPTH+1)-1:0]    out_entry_total,
  input logic [sdpl_pkg::STATUS_W-1:0] out_status
);

  localparam int               CNT_W   = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  `SDPL_ASSERT_IMPLIES(a_total_bound, out_valid, out_entry_total <= DEPTH_C, "entry total above depth")
  `SDPL_ASSERT_IMPLIES(a_full_status, out_valid && out_status == sdpl_pkg::STATUS_FULL, out_entry_total == DEPTH_C, "full status with room left")
  `SDPL_ASSERT_IMPLIES(a_empty_status, out_valid && out_status == sdpl_pkg::STATUS_EMPTY, out_entry_total == '0 && out_head_key == '0 && out_head_tag == '0, "empty status with entries held")
  `SDPL_ASSERT_IMPLIES(a_empty_head, out_valid && out_entry_total == '0, out_head_key == '0 && out_head_tag == '0, "empty list reports a head")
  `SDPL_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(out_head_key) && $stable(out_entry_total), "stalled result changed")

endmodule

bind sorted_descending_priority_list_unit sdpl_checker #(
  .DEPTH     (DEPTH),
  .KEY_WIDTH (KEY_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_sdpl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_head_tag    (out_if.head_tag),
  .out_head_key    (out_if.head_key),
  .out_entry_total (out_if.entry_total),
  .out_status      (out_if.status)
);

[tb/sv/sorted_descending_priority_list_unit_tb.sv]
// Self-checking testbench for the sorted descending priority list unit.
// Depends on sdpl_pkg, sdpl_in_if, sdpl_out_if and the unit itself.
module sorted_descending_priority_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 256;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // One operation presented on the input channel.
  typedef struct {
    logic [sdpl_pkg::FUNC_W-1:0] func;
    logic [KEY_WIDTH-1:0]        item_key;
    logic [TAG_WIDTH-1:0]        item_tag;
    logic [KEY_WIDTH-1:0]        extra_key;
    logic [TAG_WIDTH-1:0]        extra_tag;
  } list_op_t;

  // Head report that the unit returns after each operation.
  typedef struct {
    logic [TAG_WIDTH-1:0]          head_tag;
    logic [KEY_WIDTH-1:0]          head_key;
    logic [CNT_W-1:0]              entry_total;
    logic [sdpl_pkg::STATUS_W-1:0] status;
  } head_report_t;

  logic clk;
  logic rst_n;

  sdpl_in_if  #(.KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) in_ch ();
  sdpl_out_if #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) out_ch ();

  sorted_descending_priority_list_unit #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  // 12 ns period: low half first, so the first rising edge falls at 6 ns.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idling percentages, changed between the traffic phases.
  int unsigned send_idle_pct  = 38;
  int unsigned recv_stall_pct = 72;
  int unsigned mismatch_count = 0;

  // Expected head reports, oldest first.
  head_report_t head_reports_q[$];

  // ---------------------------------------------------------------------------
  // List predictor: its own copy of the sorted entries and the entry count.
  // Only positions below list_count are ever read.
  // ---------------------------------------------------------------------------
  logic [KEY_WIDTH-1:0] list_key [DEPTH];
  logic [TAG_WIDTH-1:0] list_tag [DEPTH];
  int                   list_count;

  // Put an entry ahead of the first entry whose key is not larger, so that
  // a new entry lands in front of any entries with an equal key.
  function automatic void place_sorted(logic [TAG_WIDTH-1:0] tag,
                                       logic [KEY_WIDTH-1:0] key);
    int pos;
    pos = 0;
    while (pos < list_count && list_key[pos] > key) pos++;
    for (int i = list_count; i > pos; i--) begin
      list_key[i] = list_key[i-1];
      list_tag[i] = list_tag[i-1];
    end
    list_key[pos] = key;
    list_tag[pos] = tag;
    list_count++;
  endfunction

  // Take the head away and close the gap behind it.
  function automatic void remove_head();
    for (int i = 0; i + 1 < list_count; i++) begin
      list_key[i] = list_key[i+1];
      list_tag[i] = list_tag[i+1];
    end
    list_count--;
  endfunction

  // Apply one operation to the predicted list and return the head report.
  function automatic head_report_t apply_list_op(list_op_t op);
    head_report_t         rep;
    logic [TAG_WIDTH-1:0] old_tag;
    rep.status = sdpl_pkg::STATUS_OK;
    case (op.func)
      sdpl_pkg::FUNC_LOAD: begin
        if (list_count >= DEPTH) rep.status = sdpl_pkg::STATUS_FULL;
        else place_sorted(op.item_tag, op.item_key);
      end
      sdpl_pkg::FUNC_TAIL: begin
        // The head goes last whatever its new key is; order may break here.
        if (list_count == 0) begin
          rep.status = sdpl_pkg::STATUS_EMPTY;
        end else begin
          old_tag = list_tag[0];
          remove_head();
          list_key[list_count] = op.item_key;
          list_tag[list_count] = old_tag;
          list_count++;
        end
      end
      sdpl_pkg::FUNC_POP: begin
        // Empty check wins over the full check.
        if (list_count == 0) begin
          rep.status = sdpl_pkg::STATUS_EMPTY;
        end else if (list_count >= DEPTH) begin
          rep.status = sdpl_pkg::STATUS_FULL;
        end else begin
          old_tag = list_tag[0];
          remove_head();
          place_sorted(old_tag, op.item_key);
          place_sorted(op.extra_tag, op.extra_key);
        end
      end
      default: list_count = 0;
    endcase
    if (list_count == 0) begin
      rep.head_tag = '0;
      rep.head_key = '0;
    end else begin
      rep.head_tag = list_tag[0];
      rep.head_key = list_key[0];
    end
    rep.entry_total = CNT_W'(list_count);
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random, check every accepted report in order.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic [KEY_WIDTH-1:0] exp_val,
                               logic [KEY_WIDTH-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    head_report_t exp_rep;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (head_reports_q.size() == 0) begin
        $error("head report arrived with none expected");
        mismatch_count++;
      end else begin
        exp_rep = head_reports_q.pop_front();
        compare_field("head_tag", KEY_WIDTH'(exp_rep.head_tag),
                      KEY_WIDTH'(out_ch.head_tag));
        compare_field("head_key", exp_rep.head_key, out_ch.head_key);
        compare_field("entry_total", KEY_WIDTH'(exp_rep.entry_total),
                      KEY_WIDTH'(out_ch.entry_total));
        compare_field("status", KEY_WIDTH'(exp_rep.status),
                      KEY_WIDTH'(out_ch.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Tasks are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_op(list_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.func      <= op.func;
    in_ch.item_key  <= op.item_key;
    in_ch.item_tag  <= op.item_tag;
    in_ch.extra_key <= op.extra_key;
    in_ch.extra_tag <= op.extra_tag;
    in_ch.valid     <= 1'b1;
    // Hold the item until the unit takes it, then predict its report.
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    head_reports_q.push_back(apply_list_op(op));
    @(negedge clk);
  endtask

  function automatic list_op_t make_op(logic [sdpl_pkg::FUNC_W-1:0] func,
                                       logic [KEY_WIDTH-1:0] ikey,
                                       logic [TAG_WIDTH-1:0] itag,
                                       logic [KEY_WIDTH-1:0] xkey,
                                       logic [TAG_WIDTH-1:0] xtag);
    list_op_t op;
    op.func      = func;
    op.item_key  = ikey;
    op.item_tag  = itag;
    op.extra_key = xkey;
    op.extra_tag = xtag;
    return op;
  endfunction

  // Keys bunch at the extremes and in a narrow band so that ties are common.
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_WIDTH'($urandom_range(15));
      default: return KEY_WIDTH'($urandom);
    endcase
  endfunction

  function automatic list_op_t random_op(logic [sdpl_pkg::FUNC_W-1:0] func);
    return make_op(func, pick_key(), TAG_WIDTH'($urandom), pick_key(),
                   TAG_WIDTH'($urandom));
  endfunction

  // Drop valid and hold off until every expected report has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (head_reports_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation, the empty cases, ties and the key and tag extremes.
  task automatic test_directed_ops();
    send_op(make_op(sdpl_pkg::FUNC_TAIL,  32'h1234_5678, '0, '0, '0));   // empty tail
    send_op(make_op(sdpl_pkg::FUNC_POP,   '1, '1, '1, '1));              // empty pop
    send_op(make_op(sdpl_pkg::FUNC_CLEAR, '0, '0, '0, '0));
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  '1, '1, '0, '0));
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  '0, '0, '1, '1));
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  32'h8000_0000, 16'h0001, '0, '0));
    // Tie in the middle of the list.
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  32'h8000_0000, 16'h0002, '0, '0));
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  '1, 16'h0003, '0, '0));   // tie at head
    send_op(make_op(sdpl_pkg::FUNC_TAIL,  '0, '0, '0, '0));
    send_op(make_op(sdpl_pkg::FUNC_TAIL,  '1, '0, '0, '0));         // breaks order
    send_op(make_op(sdpl_pkg::FUNC_POP,   32'h8000_0000, '0, 32'h8000_0000,
                    16'h0004));
    send_op(make_op(sdpl_pkg::FUNC_POP,   '0, '0, '1, 16'h0005));
    send_op(make_op(sdpl_pkg::FUNC_POP,   '1, '0, '1, '1));
    send_op(make_op(sdpl_pkg::FUNC_CLEAR, '1, '1, '1, '1));
    send_op(make_op(sdpl_pkg::FUNC_LOAD,  32'd5, 16'hAAAA, '0, '0));
    // Pop on a single entry.
    send_op(make_op(sdpl_pkg::FUNC_POP,   32'd5, '0, 32'd5, 16'h5555));
    send_op(make_op(sdpl_pkg::FUNC_TAIL,  32'd7, '0, '0, '0));
    send_op(make_op(sdpl_pkg::FUNC_CLEAR, '0, '0, '0, '0));
  endtask

  // Fill the list to the last place, then hit it with every operation.
  task automatic test_full_list();
    send_op(make_op(sdpl_pkg::FUNC_CLEAR, '0, '0, '0, '0));
    repeat (DEPTH) send_op(random_op(sdpl_pkg::FUNC_LOAD));
    send_op(random_op(sdpl_pkg::FUNC_LOAD));   // full, dropped
    send_op(random_op(sdpl_pkg::FUNC_POP));    // full, net gain does not fit
    send_op(random_op(sdpl_pkg::FUNC_TAIL));   // allowed, count unchanged
    send_op(random_op(sdpl_pkg::FUNC_POP));
    send_op(make_op(sdpl_pkg::FUNC_CLEAR, '0, '0, '0, '0));
  endtask

  // Mixed traffic; clears are rare so the list grows to useful depths.
  task automatic test_random_traffic(int unsigned n_ops);
    int unsigned pick;
    repeat (n_ops) begin
      pick = $urandom_range(99);
      if (pick < 40)      send_op(random_op(sdpl_pkg::FUNC_LOAD));
      else if (pick < 60) send_op(random_op(sdpl_pkg::FUNC_TAIL));
      else if (pick < 97) send_op(random_op(sdpl_pkg::FUNC_POP));
      else                send_op(random_op(sdpl_pkg::FUNC_CLEAR));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = sdpl_pkg::FUNC_LOAD;
    in_ch.item_key  = '0;
    in_ch.item_tag  = '0;
    in_ch.extra_key = '0;
    in_ch.extra_tag = '0;
    list_count      = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver stalls heavily.
    send_idle_pct  = 38;
    recv_stall_pct = 72;
    test_directed_ops();
    test_full_list();
    test_random_traffic(350);
    wait_drained();

    // Swap the pressure round.
    send_idle_pct  = 72;
    recv_stall_pct = 38;
    test_random_traffic(400);
    wait_drained();

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(330);
    wait_drained();

    // Allow for a late stray report after the last expected one.
    repeat (8) @(posedge clk);
    if (head_reports_q.size() != 0) begin
      $error("%0d head reports never arrived", head_reports_q.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/sdpl_pkg.sv
hdl/sdpl_in_if.sv
hdl/sdpl_cell.sv
hdl/sorted_descending_priority_list_unit.sv
hdl/sdpl_checker.sv
tb/sv/sorted_descending_priority_list_unit_tb.sv
